>>> rtl/epsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsm_pkg
// shared widths, register indexes, state type and result word of the
// edge period speed meter
// ----------------------------------------------------------------------------
package epsm_pkg;

   // tick counter width, 8 to 32
   localparam int COUNT_WIDTH = 16;

   localparam int DIST_W   = 16;                    // distance_scale width
   localparam int TICK_W   = 8;                     // tick_period_ms width
   localparam int DIV_W    = COUNT_WIDTH + TICK_W;  // count * tick_period_ms
   localparam int SUB_W    = DIV_W + 1;             // shared subtractor width
   localparam int STEP_W   = $clog2(DIST_W);        // divider step counter
   localparam int SPEED_W  = 16;
   localparam int SCALED_W = DIST_W + 4;            // quotient * 10
   localparam int SHOWN_W  = 10;                    // displayed value, up to 999
   localparam int DIGIT_W  = 4;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE_SCALE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_PERIOD    = CSR_INDEX_W'(1);

   localparam logic [DIST_W-1:0] DISTANCE_RESET = DIST_W'(8000);
   localparam logic [TICK_W-1:0] TICK_RESET     = TICK_W'(8);

   localparam logic [SHOWN_W-1:0] SHOWN_MAX = SHOWN_W'(999);
   localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
   localparam logic [SUB_W-1:0]   HUNDRED   = SUB_W'(100);
   localparam logic [SUB_W-1:0]   TEN       = SUB_W'(10);

   typedef enum logic [2:0] {
      CALC_IDLE,
      CALC_MUL,
      CALC_DIV,
      CALC_SCALE,
      CALC_HUND,
      CALC_TENS,
      CALC_DONE
   } calc_state_type;

   typedef struct packed {
      logic [15:0]        period_ticks;
      logic [SPEED_W-1:0] speed_value;
      logic [DIGIT_W-1:0] digit_hundreds;
      logic [DIGIT_W-1:0] digit_tens;
      logic [DIGIT_W-1:0] digit_units;
      logic               display_overflow;
      logic               zero_period;
   } epsm_result_type;

   // handshake between the front end and the calculation sequencer
   typedef struct packed {
      logic start;   // latch count and begin
      logic take;    // finished word moved to the output register
   } calc_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } calc_stat_type;

endpackage
`default_nettype wire

>>> rtl/epsm_speed_calc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epsm_speed_calc
// sequencer around one shared subtractor: restoring divide, scale by ten,
// then hundreds and tens by repeated subtraction
// ----------------------------------------------------------------------------
module epsm_speed_calc
   import epsm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire calc_ctrl_type          ctrl,
   input  wire logic [COUNT_WIDTH-1:0] count,
   input  wire logic [DIST_W-1:0]      distance_scale,
   input  wire logic [TICK_W-1:0]      tick_period_ms,
   output      calc_stat_type          stat,
   output      epsm_result_type        result
);

   calc_state_type state_ff, state_in;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [DIV_W-1:0]       div_ff, div_in;
   logic [SUB_W-1:0]       rem_ff, rem_in;
   logic [DIST_W-1:0]      quo_ff, quo_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [SPEED_W-1:0]     speed_ff, speed_in;
   logic [DIGIT_W-1:0]     hund_ff, hund_in;
   logic [DIGIT_W-1:0]     tens_ff, tens_in;
   logic                   over_ff, over_in;
   logic                   zero_ff, zero_in;

   logic [SUB_W-1:0]    sub_a, sub_b;
   logic [SUB_W:0]      diff;
   logic                borrow;
   logic [SCALED_W-1:0] scaled;
   logic [SPEED_W-1:0]  speed_sat;
   logic [31:0]         count_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CALC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      speed_ff <= speed_in;
      hund_ff  <= hund_in;
      tens_ff  <= tens_in;
      over_ff  <= over_in;
      zero_ff  <= zero_in;
   end

   // quotient times ten as two shifts, then 16 bit saturation
   assign scaled    = SCALED_W'({quo_ff, 3'b000}) + SCALED_W'({quo_ff, 1'b0});
   assign speed_sat = (scaled > SCALED_W'(SPEED_MAX)) ? SPEED_MAX : scaled[SPEED_W-1:0];

   // shared subtractor, msb is the borrow
   assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow = diff[SUB_W];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      speed_in = speed_ff;
      hund_in  = hund_ff;
      tens_in  = tens_ff;
      over_in  = over_ff;
      zero_in  = zero_ff;
      sub_a    = '0;
      sub_b    = '0;

      unique case (state_ff)
         CALC_IDLE: begin
            if (ctrl.start) begin
               count_in = count;
               state_in = CALC_MUL;
            end
         end
         CALC_MUL: begin
            div_in  = DIV_W'(count_ff) * DIV_W'(tick_period_ms);
            rem_in  = '0;
            step_in = '0;
            hund_in = '0;
            tens_in = '0;
            if (count_ff == '0 || tick_period_ms == '0) begin
               // no divisor: speed forced to zero
               quo_in   = '0;
               zero_in  = 1'b1;
               state_in = CALC_SCALE;
            end else begin
               quo_in   = distance_scale;
               zero_in  = 1'b0;
               state_in = CALC_DIV;
            end
         end
         CALC_DIV: begin
            sub_a   = {rem_ff[SUB_W-2:0], quo_ff[DIST_W-1]};
            sub_b   = {1'b0, div_ff};
            rem_in  = borrow ? sub_a : diff[SUB_W-1:0];
            quo_in  = {quo_ff[DIST_W-2:0], ~borrow};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIST_W - 1)) begin
               state_in = CALC_SCALE;
            end
         end
         CALC_SCALE: begin
            speed_in = speed_sat;
            if (speed_sat > SPEED_W'(SHOWN_MAX)) begin
               over_in = 1'b1;
               rem_in  = SUB_W'(SHOWN_MAX);
            end else begin
               over_in = 1'b0;
               rem_in  = SUB_W'(speed_sat);
            end
            state_in = CALC_HUND;
         end
         CALC_HUND: begin
            sub_a = rem_ff;
            sub_b = HUNDRED;
            if (borrow) begin
               state_in = CALC_TENS;
            end else begin
               rem_in  = diff[SUB_W-1:0];
               hund_in = hund_ff + 1'b1;
            end
         end
         CALC_TENS: begin
            sub_a = rem_ff;
            sub_b = TEN;
            if (borrow) begin
               state_in = CALC_DONE;
            end else begin
               rem_in  = diff[SUB_W-1:0];
               tens_in = tens_ff + 1'b1;
            end
         end
         CALC_DONE: begin
            if (ctrl.take) begin
               state_in = CALC_IDLE;
            end
         end
         default: begin
            state_in = CALC_IDLE;
         end
      endcase
   end

   assign count_ext = 32'(count_ff);

   assign stat.idle = (state_ff == CALC_IDLE);
   assign stat.done = (state_ff == CALC_DONE);

   assign result.period_ticks     = (count_ext > 32'h0000_FFFF) ? 16'hFFFF : count_ext[15:0];
   assign result.speed_value      = speed_ff;
   assign result.digit_hundreds   = hund_ff;
   assign result.digit_tens       = tens_ff;
   assign result.digit_units      = rem_ff[DIGIT_W-1:0];
   assign result.display_overflow = over_ff;
   assign result.zero_period      = zero_ff;

endmodule
`default_nettype wire

>>> rtl/edge_period_speed_meter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edge_period_speed_meter_unit
// period-measuring tachometer: counts ticks between rising edges of a sensor
// pin and turns each period into a speed and three display digits
// ----------------------------------------------------------------------------
// Each req word is one tick with the sampled pin level. Ticks that are not a
// rising edge are taken while the sequencer is idle and give no rsp word. A
// rising edge gives one rsp word with the ticks counted since the last edge
// and the speed (distance_scale / (count * tick_period_ms)) * 10, truncated
// and saturated to 16 bits, plus hundreds/tens/units digits of min(speed,
// 999). An edge word keeps req_ready low while the sequencer works: a multiply
// step, 16 steps of the restoring divider on the shared subtractor (skipped
// when count or tick_period_ms is zero), a scale step, then one subtract per
// hundreds and tens digit (up to 9 each, plus the final borrowing subtract of
// each digit) on the same subtractor, and a done state that hands the word
// over. A finished rsp word sits in an output register, so ticks are taken
// while it waits; a following edge holds in its final state until the output
// register frees. Registers (csr_index 0 distance_scale, 1 tick_period_ms)
// are written at any time csr_valid is high; other indexes are ignored.
// ----------------------------------------------------------------------------
module edge_period_speed_meter_unit
   import epsm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic                   req_pin_level,

   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [15:0]            rsp_period_ticks,
   output      logic [SPEED_W-1:0]     rsp_speed_value,
   output      logic [DIGIT_W-1:0]     rsp_digit_hundreds,
   output      logic [DIGIT_W-1:0]     rsp_digit_tens,
   output      logic [DIGIT_W-1:0]     rsp_digit_units,
   output      logic                   rsp_display_overflow,
   output      logic                   rsp_zero_period,

   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = {COUNT_WIDTH{1'b1}};

   // configuration
   logic [DIST_W-1:0] distance_ff, distance_in;
   logic [TICK_W-1:0] tick_ms_ff, tick_ms_in;

   // edge detect and tick counter
   logic                   prev_level_ff, prev_level_in;
   logic [COUNT_WIDTH-1:0] tick_count_ff, tick_count_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   epsm_result_type rsp_word_ff, rsp_word_in;

   logic            req_take;
   logic            rise;
   calc_ctrl_type   calc_ctrl;
   calc_stat_type   calc_stat;
   epsm_result_type calc_result;

   assign csr_ready = 1'b1;
   assign req_ready = calc_stat.idle;
   assign req_take  = req_valid & req_ready;
   assign rise      = req_pin_level & ~prev_level_ff;

   // finished word moves on when the output register is free or draining
   assign calc_ctrl.start = req_take & rise;
   assign calc_ctrl.take  = calc_stat.done & (~rsp_valid_ff | rsp_ready);

   // register writes
   always_comb begin
      distance_in = distance_ff;
      tick_ms_in  = tick_ms_ff;
      if (csr_valid & csr_ready) begin
         unique case (csr_index)
            CSR_DISTANCE_SCALE: distance_in = csr_wdata[DIST_W-1:0];
            CSR_TICK_PERIOD:    tick_ms_in  = csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // level history and saturating tick counter
   always_comb begin
      prev_level_in = prev_level_ff;
      tick_count_in = tick_count_ff;
      if (req_take) begin
         if (rise) begin
            prev_level_in = 1'b1;
            tick_count_in = '0;
         end else begin
            prev_level_in = req_pin_level;
            if (tick_count_ff != COUNT_TOP) begin
               tick_count_in = tick_count_ff + 1'b1;
            end
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (calc_ctrl.take) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = calc_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         distance_ff   <= DISTANCE_RESET;
         tick_ms_ff    <= TICK_RESET;
         prev_level_ff <= 1'b0;
         tick_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         distance_ff   <= distance_in;
         tick_ms_ff    <= tick_ms_in;
         prev_level_ff <= prev_level_in;
         tick_count_ff <= tick_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   epsm_speed_calc u_calc (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (calc_ctrl),
      .count          (tick_count_ff),
      .distance_scale (distance_ff),
      .tick_period_ms (tick_ms_ff),
      .stat           (calc_stat),
      .result         (calc_result)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_period_ticks     = rsp_word_ff.period_ticks;
   assign rsp_speed_value      = rsp_word_ff.speed_value;
   assign rsp_digit_hundreds   = rsp_word_ff.digit_hundreds;
   assign rsp_digit_tens       = rsp_word_ff.digit_tens;
   assign rsp_digit_units      = rsp_word_ff.digit_units;
   assign rsp_display_overflow = rsp_word_ff.display_overflow;
   assign rsp_zero_period      = rsp_word_ff.zero_period;

   // sequencer never takes a tick while a word is finished inside it
   a_done_not_ready: assert property (@(posedge clock) disable iff (reset)
      calc_stat.done |-> !req_ready)
      else $error("req_ready high while a result is pending in the sequencer");

   // an accepted rising edge clears the counter and arms the level history
   a_edge_clears: assert property (@(posedge clock) disable iff (reset)
      (req_take && rise) |=> (tick_count_ff == '0 && prev_level_ff))
      else $error("edge tick did not clear the counter");

   // digits are decimal
   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_hundreds <= DIGIT_W'(9) && rsp_digit_tens <= DIGIT_W'(9)
                     && rsp_digit_units <= DIGIT_W'(9)))
      else $error("display digit above nine");

   // zero period forces speed and digits to zero
   a_zero_period: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_period) |-> (rsp_speed_value == '0 && !rsp_display_overflow
                                          && rsp_digit_hundreds == '0))
      else $error("zero period word with nonzero speed");

   // overflow shows all nines
   a_overflow_nines: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_display_overflow) |-> (rsp_digit_hundreds == DIGIT_W'(9)
         && rsp_digit_tens == DIGIT_W'(9) && rsp_digit_units == DIGIT_W'(9)))
      else $error("overflow word does not show 999");

endmodule
`default_nettype wire
